FILE: rtl/sca_pkg.sv
// ============================================================================
// sca_pkg
// Shared types, constants and lookup tables of the smart card ATR parser.
// ============================================================================
`default_nettype none

package sca_pkg;

    localparam int NUM_W  = 29;
    localparam int DEN_W  = 14;
    localparam int RATE_W = 19;
    localparam int STD_W  = 17;
    localparam int TOL_W  = 6;
    localparam int F_W    = 12;
    localparam int D_W    = 6;
    localparam int CNT_W  = 5;
    localparam int K_W    = 3;
    localparam int LHS_W  = RATE_W + 7;
    localparam int RHS_W  = STD_W + TOL_W;

    localparam logic [7:0]       TS_DIRECT   = 8'h3B;
    localparam logic [7:0]       TS_INVERSE  = 8'h3F;
    localparam logic [23:0]      CARD_CLK_HZ = 24'd14318000;
    localparam logic [6:0]       PCT_SCALE   = 7'd100;
    localparam logic [K_W-1:0]   K_LAST      = 3'd4;
    localparam logic [TOL_W-1:0] TOL_DEF     = 6'd5;

    localparam logic [3:0] GROUP_FIRST = 4'd1;
    localparam logic [3:0] GROUP_TWO   = 4'd2;
    localparam logic [3:0] GROUP_MAX   = 4'd15;
    localparam logic [3:0] FI_DEF      = 4'd1;
    localparam logic [3:0] DI_DEF      = 4'd1;
    localparam logic [7:0] IFSC_DEF    = 8'd32;
    localparam logic [3:0] CWI_DEF     = 4'd13;
    localparam logic [3:0] BWI_DEF     = 4'd4;
    localparam logic [7:0] GUARD_DEF   = 8'd0;

    localparam logic REG_TOL = 1'b0;

    typedef enum logic [1:0] {
        KIND_HIST = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_T0,
        OP_IFACE,
        OP_HIST
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_T0,
        ST_IFACE,
        ST_HIST,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MATCH,
        ST_LOAD
    } state_t;

    typedef struct packed {
        op_t  op;
        logic load_bad;
        logic load_hist;
        logic finish;
        logic div_start;
        logic div_step;
        logic match_step;
        logic load_done;
    } cmd_t;

    typedef struct packed {
        logic init_ok;
        logic t0_mask_zero;
        logic t0_hist_none;
        logic mask_zero;
        logic hist_none;
        logic hist_last;
        logic rfu;
        logic div_last;
        logic match_end;
        logic out_free;
    } status_t;

    function automatic logic [F_W-1:0] f_lookup(input logic [3:0] fi);
        logic [F_W-1:0] f;
        case (fi)
            4'd0:    f = 12'd372;
            4'd1:    f = 12'd372;
            4'd2:    f = 12'd558;
            4'd3:    f = 12'd744;
            4'd4:    f = 12'd1116;
            4'd5:    f = 12'd1488;
            4'd6:    f = 12'd1860;
            4'd9:    f = 12'd512;
            4'd10:   f = 12'd768;
            4'd11:   f = 12'd1024;
            4'd12:   f = 12'd1536;
            4'd13:   f = 12'd2048;
            default: f = 12'd0;
        endcase
        return f;
    endfunction

    function automatic logic [D_W-1:0] d_lookup(input logic [3:0] di);
        logic [D_W-1:0] d;
        case (di)
            4'd1:    d = 6'd1;
            4'd2:    d = 6'd2;
            4'd3:    d = 6'd4;
            4'd4:    d = 6'd8;
            4'd5:    d = 6'd16;
            4'd6:    d = 6'd32;
            4'd8:    d = 6'd12;
            4'd9:    d = 6'd20;
            default: d = 6'd0;
        endcase
        return d;
    endfunction

    function automatic logic [STD_W-1:0] std_rate(input logic [K_W-1:0] k);
        logic [STD_W-1:0] s;
        case (k)
            3'd0:    s = 17'd9600;
            3'd1:    s = 17'd19200;
            3'd2:    s = 17'd38400;
            3'd3:    s = 17'd57600;
            3'd4:    s = 17'd115200;
            default: s = 17'd115200;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sca_if.sv
// ============================================================================
// sca_if
// Byte channel and result channel of the smart card ATR parser.
// ============================================================================
`default_nettype none

interface sca_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] atr_byte;
    logic       start_req;

    modport source (output valid, output atr_byte, output start_req, input ready);
    modport sink   (input valid, input atr_byte, input start_req, output ready);
endinterface

interface sca_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] hist_byte;
    logic       hist_valid;
    logic [3:0] hist_index;
    logic [3:0] fi_code;
    logic [3:0] di_code;
    logic [7:0] info_field_size;
    logic [3:0] char_wait_index;
    logic [3:0] block_wait_index;
    logic [7:0] extra_guard;
    logic [3:0] hist_count;
    logic [2:0] baud_code;

    modport source (
        output valid, output kind, output hist_byte, output hist_valid, output hist_index,
        output fi_code, output di_code, output info_field_size, output char_wait_index,
        output block_wait_index, output extra_guard, output hist_count, output baud_code,
        input ready
    );
    modport sink (
        input valid, input kind, input hist_byte, input hist_valid, input hist_index,
        input fi_code, input di_code, input info_field_size, input char_wait_index,
        input block_wait_index, input extra_guard, input hist_count, input baud_code,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/sca_ctrl.sv
// ============================================================================
// sca_ctrl
// Parse sequencer: follows the ATR phases and steps the baud calculation.
// ============================================================================
`default_nettype none

module sca_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             start_req,
    output logic                  in_ready,
    input  wire sca_pkg::status_t sts,
    output sca_pkg::cmd_t         cmd
);

    sca_pkg::state_t state_reg;
    sca_pkg::state_t state_next;
    logic            parse_state;
    logic            accept;
    logic            restart;
    logic            group_done;
    logic            no_hist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sca_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        parse_state = (state_reg == sca_pkg::ST_INIT) || (state_reg == sca_pkg::ST_T0)
                   || (state_reg == sca_pkg::ST_IFACE) || (state_reg == sca_pkg::ST_HIST)
                   || (state_reg == sca_pkg::ST_IDLE);
        in_ready   = parse_state && sts.out_free;
        accept     = in_valid && in_ready;
        restart    = start_req || (state_reg == sca_pkg::ST_INIT);
        group_done = (state_reg == sca_pkg::ST_T0) ? sts.t0_mask_zero : sts.mask_zero;
        no_hist    = (state_reg == sca_pkg::ST_T0) ? sts.t0_hist_none : sts.hist_none;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sca_pkg::ST_INIT, sca_pkg::ST_T0, sca_pkg::ST_IFACE,
            sca_pkg::ST_HIST, sca_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        state_next = sts.init_ok ? sca_pkg::ST_T0 : sca_pkg::ST_IDLE;
                    end
                    else if (state_reg == sca_pkg::ST_HIST)
                    begin
                        state_next = sts.hist_last ? sca_pkg::ST_PREP : sca_pkg::ST_HIST;
                    end
                    else if (state_reg == sca_pkg::ST_T0 || state_reg == sca_pkg::ST_IFACE)
                    begin
                        if (!group_done)
                        begin
                            state_next = sca_pkg::ST_IFACE;
                        end
                        else if (no_hist)
                        begin
                            state_next = sca_pkg::ST_PREP;
                        end
                        else
                        begin
                            state_next = sca_pkg::ST_HIST;
                        end
                    end
                end
            end
            sca_pkg::ST_PREP:
            begin
                state_next = sca_pkg::ST_DIV;
            end
            sca_pkg::ST_DIV:
            begin
                if (sts.rfu)
                begin
                    state_next = sca_pkg::ST_LOAD;
                end
                else if (sts.div_last)
                begin
                    state_next = sca_pkg::ST_MATCH;
                end
            end
            sca_pkg::ST_MATCH:
            begin
                if (sts.match_end)
                begin
                    state_next = sca_pkg::ST_LOAD;
                end
            end
            sca_pkg::ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = sca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sca_pkg::ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.op = sca_pkg::OP_NONE;
        case (state_reg)
            sca_pkg::ST_INIT, sca_pkg::ST_T0, sca_pkg::ST_IFACE,
            sca_pkg::ST_HIST, sca_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        cmd.op       = sca_pkg::OP_START;
                        cmd.load_bad = !sts.init_ok;
                    end
                    else if (state_reg == sca_pkg::ST_HIST)
                    begin
                        cmd.op        = sca_pkg::OP_HIST;
                        cmd.finish    = sts.hist_last;
                        cmd.load_hist = !sts.hist_last;
                    end
                    else if (state_reg == sca_pkg::ST_T0)
                    begin
                        cmd.op     = sca_pkg::OP_T0;
                        cmd.finish = group_done && no_hist;
                    end
                    else if (state_reg == sca_pkg::ST_IFACE)
                    begin
                        cmd.op     = sca_pkg::OP_IFACE;
                        cmd.finish = group_done && no_hist;
                    end
                end
            end
            sca_pkg::ST_PREP:
            begin
                cmd.div_start = 1'b1;
            end
            sca_pkg::ST_DIV:
            begin
                cmd.div_step = !sts.rfu;
            end
            sca_pkg::ST_MATCH:
            begin
                cmd.match_step = 1'b1;
            end
            sca_pkg::ST_LOAD:
            begin
                cmd.load_done = sts.out_free;
            end
            default:
            begin
                cmd.op = sca_pkg::OP_NONE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sca_pkg::ST_DIV || state_reg == sca_pkg::ST_MATCH) |-> !in_ready)
        else $error("byte taken during baud calculation");
    a_finish_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == sca_pkg::ST_PREP)
        else $error("completion did not start baud calculation");
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_done |=> state_reg == sca_pkg::ST_IDLE)
        else $error("completion result not followed by idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/sca_dp.sv
// ============================================================================
// sca_dp
// Datapath: ATR parameter registers, baud divider and matcher, result register.
// ============================================================================
`default_nettype none

module sca_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [7:0]                atr_byte,
    input  wire logic [sca_pkg::TOL_W-1:0] tol,
    input  wire sca_pkg::cmd_t             cmd,
    output sca_pkg::status_t               sts,
    sca_out_if.source                      res
);

    logic [3:0] group_reg;
    logic [3:0] mask_reg;
    logic [3:0] fi_reg;
    logic [3:0] di_reg;
    logic [7:0] ifsc_reg;
    logic [3:0] cwi_reg;
    logic [3:0] bwi_reg;
    logic [7:0] guard_reg;
    logic [3:0] hist_total_reg;
    logic [3:0] hist_seen_reg;

    logic [7:0] fin_byte_reg;
    logic       fin_valid_reg;
    logic [3:0] fin_index_reg;

    logic [sca_pkg::NUM_W-1:0] num_reg;
    logic [sca_pkg::DEN_W-1:0] den_reg;
    logic [sca_pkg::DEN_W-1:0] rem_reg;
    logic [sca_pkg::CNT_W-1:0] cnt_reg;
    logic                      rfu_reg;
    logic [sca_pkg::K_W-1:0]   k_reg;
    logic [2:0]                baud_reg;

    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] hbyte_reg;
    logic       hvalid_reg;
    logic [3:0] hindex_reg;
    logic [3:0] fi_out_reg;
    logic [3:0] di_out_reg;
    logic [7:0] ifsc_out_reg;
    logic [3:0] cwi_out_reg;
    logic [3:0] bwi_out_reg;
    logic [7:0] guard_out_reg;
    logic [3:0] hcount_out_reg;
    logic [2:0] baud_out_reg;

    logic [3:0]                mask_iface;
    logic [3:0]                seen_inc;
    logic [sca_pkg::F_W-1:0]   f_val;
    logic [sca_pkg::D_W-1:0]   d_val;
    logic [sca_pkg::NUM_W:0]   num_full;
    logic [sca_pkg::DEN_W:0]   rem_sh;
    logic                      rem_ge;
    logic [sca_pkg::RATE_W-1:0] rate;
    logic [sca_pkg::RATE_W-1:0] std_ext;
    logic [sca_pkg::RATE_W-1:0] diff;
    logic [sca_pkg::LHS_W-1:0] lhs;
    logic [sca_pkg::RHS_W-1:0] rhs;
    logic                      hit;
    logic                      load_any;

    always_comb
    begin
        if (mask_reg[0])
        begin
            mask_iface = mask_reg & 4'b1110;
        end
        else if (mask_reg[1])
        begin
            mask_iface = mask_reg & 4'b1101;
        end
        else if (mask_reg[2])
        begin
            mask_iface = mask_reg & 4'b1011;
        end
        else
        begin
            mask_iface = atr_byte[7:4];
        end
        seen_inc = hist_seen_reg + 4'd1;

        f_val    = sca_pkg::f_lookup(fi_reg);
        d_val    = sca_pkg::d_lookup(di_reg);
        num_full = sca_pkg::CARD_CLK_HZ * d_val;

        rem_sh = {rem_reg, num_reg[sca_pkg::NUM_W-1]};
        rem_ge = rem_sh >= {1'b0, den_reg};

        rate    = num_reg[sca_pkg::RATE_W-1:0];
        std_ext = sca_pkg::RATE_W'(sca_pkg::std_rate(k_reg));
        diff    = (rate >= std_ext) ? (rate - std_ext) : (std_ext - rate);
        lhs     = sca_pkg::LHS_W'(diff) * sca_pkg::LHS_W'(sca_pkg::PCT_SCALE);
        rhs     = sca_pkg::RHS_W'(sca_pkg::std_rate(k_reg)) * sca_pkg::RHS_W'(tol);
        hit     = lhs <= sca_pkg::LHS_W'(rhs);
    end

    assign load_any = cmd.load_bad || cmd.load_hist || cmd.load_done;

    always_comb
    begin
        sts.init_ok      = (atr_byte == sca_pkg::TS_DIRECT) || (atr_byte == sca_pkg::TS_INVERSE);
        sts.t0_mask_zero = atr_byte[7:4] == 4'd0;
        sts.t0_hist_none = atr_byte[3:0] == 4'd0;
        sts.mask_zero    = mask_iface == 4'd0;
        sts.hist_none    = hist_total_reg == 4'd0;
        sts.hist_last    = seen_inc >= hist_total_reg;
        sts.rfu          = rfu_reg;
        sts.div_last     = cnt_reg == sca_pkg::CNT_W'(sca_pkg::NUM_W - 1);
        sts.match_end    = hit || (k_reg == sca_pkg::K_LAST);
        sts.out_free     = !out_valid_reg || res.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg      <= sca_pkg::GROUP_FIRST;
            mask_reg       <= 4'd0;
            fi_reg         <= sca_pkg::FI_DEF;
            di_reg         <= sca_pkg::DI_DEF;
            ifsc_reg       <= sca_pkg::IFSC_DEF;
            cwi_reg        <= sca_pkg::CWI_DEF;
            bwi_reg        <= sca_pkg::BWI_DEF;
            guard_reg      <= sca_pkg::GUARD_DEF;
            hist_total_reg <= 4'd0;
            hist_seen_reg  <= 4'd0;
        end
        else
        begin
            case (cmd.op)
                sca_pkg::OP_START:
                begin
                    group_reg      <= sca_pkg::GROUP_FIRST;
                    mask_reg       <= 4'd0;
                    fi_reg         <= sca_pkg::FI_DEF;
                    di_reg         <= sca_pkg::DI_DEF;
                    ifsc_reg       <= sca_pkg::IFSC_DEF;
                    cwi_reg        <= sca_pkg::CWI_DEF;
                    bwi_reg        <= sca_pkg::BWI_DEF;
                    guard_reg      <= sca_pkg::GUARD_DEF;
                    hist_total_reg <= 4'd0;
                    hist_seen_reg  <= 4'd0;
                end
                sca_pkg::OP_T0:
                begin
                    hist_total_reg <= atr_byte[3:0];
                    mask_reg       <= atr_byte[7:4];
                    group_reg      <= sca_pkg::GROUP_FIRST;
                end
                sca_pkg::OP_IFACE:
                begin
                    mask_reg <= mask_iface;
                    if (mask_reg[0])
                    begin
                        if (group_reg == sca_pkg::GROUP_FIRST)
                        begin
                            fi_reg <= atr_byte[7:4];
                            di_reg <= atr_byte[3:0];
                        end
                        else if (group_reg > sca_pkg::GROUP_TWO)
                        begin
                            ifsc_reg <= atr_byte;
                        end
                    end
                    else if (mask_reg[1])
                    begin
                        if (group_reg > sca_pkg::GROUP_TWO)
                        begin
                            cwi_reg <= atr_byte[3:0];
                            bwi_reg <= atr_byte[7:4];
                        end
                    end
                    else if (mask_reg[2])
                    begin
                        if (group_reg == sca_pkg::GROUP_FIRST)
                        begin
                            guard_reg <= atr_byte;
                        end
                    end
                    else if (group_reg != sca_pkg::GROUP_MAX)
                    begin
                        group_reg <= group_reg + 4'd1;
                    end
                end
                sca_pkg::OP_HIST:
                begin
                    hist_seen_reg <= seen_inc;
                end
                default:
                begin
                    hist_seen_reg <= hist_seen_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            fin_valid_reg <= cmd.op == sca_pkg::OP_HIST;
            fin_byte_reg  <= (cmd.op == sca_pkg::OP_HIST) ? atr_byte : 8'd0;
            fin_index_reg <= (cmd.op == sca_pkg::OP_HIST) ? hist_seen_reg : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rfu_reg  <= 1'b0;
            k_reg    <= '0;
            baud_reg <= 3'd0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg  <= '0;
            rfu_reg  <= (f_val == '0) || (d_val == '0);
            k_reg    <= '0;
            baud_reg <= 3'd0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + sca_pkg::CNT_W'(1);
        end
        else if (cmd.match_step)
        begin
            k_reg <= k_reg + sca_pkg::K_W'(1);
            if (hit)
            begin
                baud_reg <= 3'(k_reg) + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= num_full[sca_pkg::NUM_W-1:0];
            den_reg <= {f_val, 2'b00};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[sca_pkg::NUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? sca_pkg::DEN_W'(rem_sh - {1'b0, den_reg})
                              : rem_sh[sca_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_bad)
        begin
            kind_reg       <= sca_pkg::KIND_BAD;
            hbyte_reg      <= 8'd0;
            hvalid_reg     <= 1'b0;
            hindex_reg     <= 4'd0;
            fi_out_reg     <= 4'd0;
            di_out_reg     <= 4'd0;
            ifsc_out_reg   <= 8'd0;
            cwi_out_reg    <= 4'd0;
            bwi_out_reg    <= 4'd0;
            guard_out_reg  <= 8'd0;
            hcount_out_reg <= 4'd0;
            baud_out_reg   <= 3'd0;
        end
        else if (cmd.load_hist)
        begin
            kind_reg       <= sca_pkg::KIND_HIST;
            hbyte_reg      <= atr_byte;
            hvalid_reg     <= 1'b1;
            hindex_reg     <= hist_seen_reg;
            fi_out_reg     <= 4'd0;
            di_out_reg     <= 4'd0;
            ifsc_out_reg   <= 8'd0;
            cwi_out_reg    <= 4'd0;
            bwi_out_reg    <= 4'd0;
            guard_out_reg  <= 8'd0;
            hcount_out_reg <= 4'd0;
            baud_out_reg   <= 3'd0;
        end
        else if (cmd.load_done)
        begin
            kind_reg       <= sca_pkg::KIND_DONE;
            hbyte_reg      <= fin_byte_reg;
            hvalid_reg     <= fin_valid_reg;
            hindex_reg     <= fin_index_reg;
            fi_out_reg     <= fi_reg;
            di_out_reg     <= di_reg;
            ifsc_out_reg   <= ifsc_reg;
            cwi_out_reg    <= cwi_reg;
            bwi_out_reg    <= bwi_reg;
            guard_out_reg  <= guard_reg;
            hcount_out_reg <= hist_total_reg;
            baud_out_reg   <= baud_reg;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.kind             = kind_reg;
    assign res.hist_byte        = hbyte_reg;
    assign res.hist_valid       = hvalid_reg;
    assign res.hist_index       = hindex_reg;
    assign res.fi_code          = fi_out_reg;
    assign res.di_code          = di_out_reg;
    assign res.info_field_size  = ifsc_out_reg;
    assign res.char_wait_index  = cwi_out_reg;
    assign res.block_wait_index = bwi_out_reg;
    assign res.extra_guard      = guard_out_reg;
    assign res.hist_count       = hcount_out_reg;
    assign res.baud_code        = baud_out_reg;

`ifndef SYNTHESIS
    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_bad, cmd.load_hist, cmd.load_done}))
        else $error("more than one result loaded at once");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |-> !load_any)
        else $error("pending result overwritten");
    a_no_match_on_rfu: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.match_step |-> !rfu_reg)
        else $error("rate match run on a reserved F or D entry");
`endif

endmodule

`default_nettype wire

FILE: rtl/smart_card_atr_parser.sv
// ============================================================================
// smart_card_atr_parser
// ISO 7816 answer-to-reset parser with APB tolerance register.
// ============================================================================
// Takes one ATR byte per cycle while parsing and while no result waits;
// historical bytes and a bad initial character show their result in the cycle
// after the byte is taken. The completion result follows the last ATR byte
// through a set-up step, the restoring divider that yields one quotient bit
// per cycle, rate compares against up to five standard rates and the result
// load, with the compares skipped when F or D is reserved; no byte is taken
// in that time. The baud match tolerance register sits at byte address 0 and
// resets to 5.
`default_nettype none

module smart_card_atr_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    sca_in_if.sink           in_ch,
    sca_out_if.source        res_ch
);

    logic [sca_pkg::TOL_W-1:0] tol_reg;
    sca_pkg::cmd_t             cmd;
    sca_pkg::status_t          sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sca_pkg::REG_TOL) ? 32'(tol_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= sca_pkg::TOL_DEF;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == sca_pkg::REG_TOL))
        begin
            tol_reg <= pwdata[sca_pkg::TOL_W-1:0];
        end
    end

    sca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .start_req (in_ch.start_req),
        .in_ready  (in_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sca_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .atr_byte (in_ch.atr_byte),
        .tol      (tol_reg),
        .cmd      (cmd),
        .sts      (sts),
        .res      (res_ch)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the smart card ATR parser. A scoreboard class tracks
// the parse of every accepted ATR byte and queues the result transactions it
// implies; each result transaction taken from the block is checked field by
// field against the oldest one queued. Stimulus is a short directed opening,
// then random well-formed, truncated and broken answer-to-reset sequences
// under several baud match tolerances, with random gaps and stalls on both
// channels.
// ============================================================================

module tb;

    typedef struct packed {
        sca_pkg::kind_t kind;
        logic [7:0]     hist_byte;
        logic           hist_valid;
        logic [3:0]     hist_index;
        logic [3:0]     fi_code;
        logic [3:0]     di_code;
        logic [7:0]     info_field_size;
        logic [3:0]     char_wait_index;
        logic [3:0]     block_wait_index;
        logic [7:0]     extra_guard;
        logic [3:0]     hist_count;
        logic [2:0]     baud_code;
    } atr_result_t;

    typedef struct {
        logic [7:0] b;
        logic       s;
    } atr_item_t;

    typedef enum logic [2:0] {
        PH_WAIT_TS,
        PH_WAIT_T0,
        PH_IFACE,
        PH_HIST,
        PH_DONE
    } parse_phase_t;

    localparam int unsigned F_CLOCKS [16] = '{372, 372, 558, 744, 1116, 1488, 1860, 0,
                                              0, 512, 768, 1024, 1536, 2048, 0, 0};
    localparam int unsigned D_FACTORS [16] = '{0, 1, 2, 4, 8, 16, 32, 0,
                                               12, 20, 0, 0, 0, 0, 0, 0};
    localparam int unsigned STD_BAUDS [5] = '{9600, 19200, 38400, 57600, 115200};
    localparam int unsigned TOL_PLAN [6] = '{0, 63, 50, 1, 20, 5};
    localparam logic [7:0] TA1_PICKS [8] = '{8'h11, 8'h12, 8'h13, 8'h18,
                                             8'h38, 8'h94, 8'h96, 8'h01};
    localparam logic [8:0] OPENING [26] = '{
        9'h03B, 9'h000, 9'h05C,
        9'h13F, 9'h0F2, 9'h018, 9'h0FF, 9'h0FF, 9'h0F0, 9'h0A5, 9'h05A,
        9'h000, 9'h030, 9'h0FF, 9'h000, 9'h000, 9'h0FF,
        9'h100, 9'h03B, 9'h1FF,
        9'h13B, 9'h015, 9'h097, 9'h13B, 9'h001, 9'h0A5
    };
    localparam int SETTLE_CYCLES = 50;
    localparam int PHASE_ITEMS   = 130;

    class atr_param_tracker;
        atr_result_t  due_results[$];
        int unsigned  mismatch_count;
        logic [5:0]   tolerance;
        parse_phase_t phase;
        logic [3:0]   level;
        logic [3:0]   pending;
        logic [3:0]   fi;
        logic [3:0]   di;
        logic [7:0]   ifsc;
        logic [3:0]   cwi;
        logic [3:0]   bwi;
        logic [7:0]   guard;
        logic [3:0]   hist_total;
        logic [3:0]   hist_seen;

        function new();
            mismatch_count = 0;
            tolerance      = sca_pkg::TOL_DEF;
            phase          = PH_WAIT_TS;
            restore_defaults();
        endfunction

        function void restore_defaults();
            level      = sca_pkg::GROUP_FIRST;
            pending    = 4'd0;
            fi         = sca_pkg::FI_DEF;
            di         = sca_pkg::DI_DEF;
            ifsc       = sca_pkg::IFSC_DEF;
            cwi        = sca_pkg::CWI_DEF;
            bwi        = sca_pkg::BWI_DEF;
            guard      = sca_pkg::GUARD_DEF;
            hist_total = 4'd0;
            hist_seen  = 4'd0;
        endfunction

        function logic [2:0] rate_code();
            longint unsigned f_val;
            longint unsigned d_val;
            longint unsigned rate;
            longint unsigned target;
            longint unsigned diff;
            f_val = F_CLOCKS[fi];
            d_val = D_FACTORS[di];
            if (f_val == 0 || d_val == 0)
                return 3'd0;
            rate = (longint'(sca_pkg::CARD_CLK_HZ) * d_val) / (f_val * 4);
            for (int k = 0; k < 5; k++)
            begin
                target = STD_BAUDS[k];
                diff = (rate > target) ? rate - target : target - rate;
                if (diff * 100 <= target * tolerance)
                    return 3'(k + 1);
            end
            return 3'd0;
        endfunction

        function void complete(logic [7:0] b, logic v, logic [3:0] idx);
            atr_result_t r;
            r                  = '0;
            r.kind             = sca_pkg::KIND_DONE;
            r.hist_byte        = b;
            r.hist_valid       = v;
            r.hist_index       = idx;
            r.fi_code          = fi;
            r.di_code          = di;
            r.info_field_size  = ifsc;
            r.char_wait_index  = cwi;
            r.block_wait_index = bwi;
            r.extra_guard      = guard;
            r.hist_count       = hist_total;
            r.baud_code        = rate_code();
            due_results.push_back(r);
            phase = PH_DONE;
        endfunction

        function void group_end();
            if (pending != 4'd0)
                return;
            if (hist_total != 4'd0)
                phase = PH_HIST;
            else
                complete(8'h00, 1'b0, 4'd0);
        endfunction

        function void take_byte(logic [7:0] b, logic s);
            atr_result_t r;
            logic [3:0]  idx;
            r = '0;
            if (s || phase == PH_WAIT_TS)
            begin
                restore_defaults();
                if (b != sca_pkg::TS_DIRECT && b != sca_pkg::TS_INVERSE)
                begin
                    phase  = PH_DONE;
                    r.kind = sca_pkg::KIND_BAD;
                    due_results.push_back(r);
                end
                else
                    phase = PH_WAIT_T0;
                return;
            end
            case (phase)
                PH_WAIT_T0:
                begin
                    hist_total = b[3:0];
                    pending    = b[7:4];
                    level      = sca_pkg::GROUP_FIRST;
                    phase      = PH_IFACE;
                    group_end();
                end
                PH_IFACE:
                begin
                    if (pending[0])
                    begin
                        pending[0] = 1'b0;
                        if (level == sca_pkg::GROUP_FIRST)
                        begin
                            fi = b[7:4];
                            di = b[3:0];
                        end
                        else if (level > sca_pkg::GROUP_TWO)
                            ifsc = b;
                    end
                    else if (pending[1])
                    begin
                        pending[1] = 1'b0;
                        if (level > sca_pkg::GROUP_TWO)
                        begin
                            cwi = b[3:0];
                            bwi = b[7:4];
                        end
                    end
                    else if (pending[2])
                    begin
                        pending[2] = 1'b0;
                        if (level == sca_pkg::GROUP_FIRST)
                            guard = b;
                    end
                    else
                    begin
                        pending = b[7:4];
                        if (level < sca_pkg::GROUP_MAX)
                            level = level + 4'd1;
                    end
                    group_end();
                end
                PH_HIST:
                begin
                    idx       = hist_seen;
                    hist_seen = hist_seen + 4'd1;
                    if (hist_seen >= hist_total)
                        complete(b, 1'b1, idx);
                    else
                    begin
                        r.kind       = sca_pkg::KIND_HIST;
                        r.hist_byte  = b;
                        r.hist_valid = 1'b1;
                        r.hist_index = idx;
                        due_results.push_back(r);
                    end
                end
                default:
                    return;
            endcase
        endfunction

        function void cmp(string name, logic [7:0] e, logic [7:0] a);
            if (a !== e)
            begin
                $display("%0t: %s expected %0h got %0h", $time, name, e, a);
                mismatch_count++;
            end
        endfunction

        function void match_result(atr_result_t got);
            atr_result_t e;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing got %h",
                         $time, got);
                mismatch_count++;
                return;
            end
            e = due_results.pop_front();
            cmp("kind", e.kind, got.kind);
            cmp("hist_byte", e.hist_byte, got.hist_byte);
            cmp("hist_valid", e.hist_valid, got.hist_valid);
            cmp("hist_index", e.hist_index, got.hist_index);
            cmp("fi_code", e.fi_code, got.fi_code);
            cmp("di_code", e.di_code, got.di_code);
            cmp("info_field_size", e.info_field_size, got.info_field_size);
            cmp("char_wait_index", e.char_wait_index, got.char_wait_index);
            cmp("block_wait_index", e.block_wait_index, got.block_wait_index);
            cmp("extra_guard", e.extra_guard, got.extra_guard);
            cmp("hist_count", e.hist_count, got.hist_count);
            cmp("baud_code", e.baud_code, got.baud_code);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bit          src_steady;
    bit          snk_steady;
    int          sent_items;
    atr_item_t   byte_q[$];

    atr_param_tracker tracker = new();

    sca_in_if  in_ch();
    sca_out_if res_ch();

    smart_card_atr_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .res_ch  (res_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic push(input logic [7:0] b, input logic s);
        atr_item_t it;
        it.b = b;
        it.s = s;
        byte_q.push_back(it);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.atr_byte  <= b;
        in_ch.start_req <= s;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        tracker.take_byte(b, s);
        sent_items++;
    endtask

    task automatic send_all();
        atr_item_t it;
        while (byte_q.size() != 0)
        begin
            it = byte_q.pop_front();
            send_byte(it.b, it.s);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tolerance(input int tol_v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sca_pkg::REG_TOL, 2'b00};
        pwdata  <= 32'(tol_v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.tolerance = 6'(tol_v);
    endtask

    task automatic build_atr(input bit trunc);
        logic [3:0] mask;
        logic [3:0] hist_k;
        bit         deep;
        bit         td;
        int         groups;
        int         cut;
        deep   = ($urandom_range(0, 9) == 0);
        hist_k = 4'($urandom_range(0, 15));
        mask   = 4'($urandom_range(0, 15));
        if (deep)
            mask[3] = 1'b1;
        push($urandom_range(0, 1) ? sca_pkg::TS_DIRECT : sca_pkg::TS_INVERSE, 1'b1);
        push({mask, hist_k}, 1'b0);
        groups = 1;
        forever
        begin
            if (mask[0])
                push((groups == 1 && $urandom_range(0, 1)) ? TA1_PICKS[$urandom_range(0, 7)]
                                                           : 8'($urandom), 1'b0);
            if (mask[1])
                push(8'($urandom), 1'b0);
            if (mask[2])
                push(8'($urandom), 1'b0);
            if (!mask[3])
                break;
            td = (groups < (deep ? 18 : 6)) &&
                 ($urandom_range(0, 99) < (deep ? 95 : 45));
            mask = {td, 3'($urandom)};
            push({mask, 4'($urandom)}, 1'b0);
            groups++;
        end
        repeat (hist_k) push(8'($urandom), 1'b0);
        if ($urandom_range(0, 3) == 0)
            push(8'($urandom), 1'b0);
        if (trunc && byte_q.size() > 1)
        begin
            cut = $urandom_range(1, byte_q.size() - 1);
            while (byte_q.size() > cut)
                void'(byte_q.pop_back());
        end
    endtask

    task automatic random_phase(input int count);
        int goal;
        int pick;
        logic [7:0] bad_ts;
        goal = sent_items + count;
        while (sent_items < goal)
        begin
            if ($urandom_range(0, 5) == 0)
                src_steady = ~src_steady;
            if ($urandom_range(0, 5) == 0)
                snk_steady = ~snk_steady;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                build_atr($urandom_range(0, 6) == 0);
            else if (pick < 90)
            begin
                do bad_ts = 8'($urandom);
                while (bad_ts == sca_pkg::TS_DIRECT || bad_ts == sca_pkg::TS_INVERSE);
                push(bad_ts, 1'b1);
                repeat ($urandom_range(0, 3)) push(8'($urandom), 1'b0);
            end
            else
                repeat ($urandom_range(1, 6)) push(8'($urandom), 1'($urandom));
            send_all();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.atr_byte  <= '0;
        in_ch.start_req <= 1'b0;
        sent_items      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING[i])
            push(OPENING[i][7:0], OPENING[i][8]);
        send_all();
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_tolerance(p == 4 ? $urandom_range(0, 63) : TOL_PLAN[p]);
            random_phase(PHASE_ITEMS);
            drain();
        end

        if (tracker.mismatch_count == 0 && tracker.due_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        atr_result_t got;
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = snk_steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            got.kind             = sca_pkg::kind_t'(res_ch.kind);
            got.hist_byte        = res_ch.hist_byte;
            got.hist_valid       = res_ch.hist_valid;
            got.hist_index       = res_ch.hist_index;
            got.fi_code          = res_ch.fi_code;
            got.di_code          = res_ch.di_code;
            got.info_field_size  = res_ch.info_field_size;
            got.char_wait_index  = res_ch.char_wait_index;
            got.block_wait_index = res_ch.block_wait_index;
            got.extra_guard      = res_ch.extra_guard;
            got.hist_count       = res_ch.hist_count;
            got.baud_code        = res_ch.baud_code;
            tracker.match_result(got);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: smart_card_atr_parser.f
rtl/sca_pkg.sv
rtl/sca_if.sv
rtl/sca_ctrl.sv
rtl/sca_dp.sv
rtl/smart_card_atr_parser.sv
verif/tb.sv
